@@ hw/rtl/omk_pkg.sv @@
package omk_pkg;

	localparam int IN_W      = 8;
	localparam int WHEEL_W   = 11;
	localparam int SPIN_W    = 10;
	localparam int SPROD_W   = 19;
	localparam int MAG2_W    = 16;
	localparam int MAGQ_W    = 16;
	localparam int S_TDATA_W = 24;
	localparam int M_FIELD_W = 3 * WHEEL_W + 1;
	localparam int M_TDATA_W = 40;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	// sqrt(3) in Q16
	localparam logic [16:0] SQRT3_Q16 = 17'd113512;

	localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
	localparam logic [1:0] REG_SPIN_GAIN = 2'd1;
	localparam logic [1:0] REG_SPEED_MIN = 2'd2;
	localparam logic [1:0] REG_SPEED_MAX = 2'd3;

	localparam logic [6:0] DEAD_ZONE_RST = 7'd10;
	localparam logic [9:0] SPIN_GAIN_RST = 10'd256;
	localparam logic [7:0] SPEED_MIN_RST = 8'd0;
	localparam logic [7:0] SPEED_MAX_RST = 8'd100;

	typedef struct packed {
		logic signed [IN_W-1:0]    x;
		logic signed [IN_W-1:0]    y;
		logic signed [SPROD_W-1:0] sprod;
	} omk_stick_t;

endpackage

@@ hw/rtl/three_wheel_omni_kinematics_top.sv @@
// Throughput: one item per cycle; the whole pipeline advances together and
// holds in place while a result waits on m_axis_tready.
// The sqrt (8 stages) and two long dividers (5 and 10 stages) set the depth.
// Reset (arst_n low, async) empties the pipeline and restores register defaults.
module three_wheel_omni_kinematics_top import omk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // x_in, y_in, spin_in
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // wheel_left, wheel_right, wheel_tail, was_scaled
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready
);

	localparam int LN_L = 0;
	localparam int LN_R = 1;
	localparam int LN_T = 2;
	localparam int DOT_W  = 27;
	localparam int PROD_W = 36;
	localparam int N1_W   = 25;
	localparam int Q1_W   = 10;
	localparam int N2_W   = 21;
	localparam int Q2_W   = 20;
	localparam int D2_W   = 10;

	typedef struct packed {
		logic [2:0]                    neg;
		logic signed [SPIN_W-1:0]      spin;
	} omk_mid_t;

	typedef struct packed {
		logic [2:0][WHEEL_W-1:0]       p;
		logic signed [SPIN_W-1:0]      spin;
		logic                          scl;
		logic                          dz;
		logic [2:0]                    neg;
	} omk_tail_t;

	// configuration
	logic [6:0] dead_zone_q;
	logic [9:0] spin_gain_q;
	logic [7:0] speed_min_q;
	logic [7:0] speed_max_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= DEAD_ZONE_RST;
			spin_gain_q <= SPIN_GAIN_RST;
			speed_min_q <= SPEED_MIN_RST;
			speed_max_q <= SPEED_MAX_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_DEAD_ZONE: dead_zone_q <= pwdata[6:0];
				REG_SPIN_GAIN: spin_gain_q <= pwdata[9:0];
				REG_SPEED_MIN: speed_min_q <= pwdata[7:0];
				REG_SPEED_MAX: speed_max_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DEAD_ZONE: prdata = APB_DW'(dead_zone_q);
			REG_SPIN_GAIN: prdata = APB_DW'(spin_gain_q);
			REG_SPEED_MIN: prdata = APB_DW'(speed_min_q);
			REG_SPEED_MAX: prdata = APB_DW'(speed_max_q);
			default:       prdata = '0;
		endcase
	end

	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	function automatic logic signed [IN_W-1:0] dz_apply(input logic signed [IN_W-1:0] v,
		input logic [6:0] dz);
		logic [IN_W-1:0] a;
		a = v[IN_W-1] ? IN_W'(-v) : IN_W'(v);
		return (a < {1'b0, dz}) ? '0 : v;
	endfunction

	// s1: dead zone, squares, spin product
	logic signed [IN_W-1:0]    x_c, y_c, sp_c;
	logic signed [15:0]        xx_c, yy_c;
	logic signed [SPROD_W-1:0] sprod_c;
	logic                      vld_s1;
	omk_stick_t                st_s1;
	logic [MAG2_W-1:0]         mag2_s1;

	always_comb begin
		x_c     = dz_apply(s_axis_tdata[7:0], dead_zone_q);
		y_c     = dz_apply(s_axis_tdata[15:8], dead_zone_q);
		sp_c    = dz_apply(s_axis_tdata[23:16], dead_zone_q);
		xx_c    = x_c * x_c;
		yy_c    = y_c * y_c;
		sprod_c = $signed({1'b0, spin_gain_q}) * sp_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1.x     <= x_c;
			st_s1.y     <= y_c;
			st_s1.sprod <= sprod_c;
			mag2_s1     <= MAG2_W'(xx_c) + MAG2_W'(yy_c);
		end
	end

	// magnitude in Q8
	logic              sq_vld;
	logic [MAGQ_W-1:0] magq;
	omk_stick_t        sq_st;

	omk_sqrt #(
		.SIDE_W ($bits(omk_stick_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.in_mag2  (mag2_s1),
		.in_side  (st_s1),
		.out_vld  (sq_vld),
		.out_root (magq),
		.out_side (sq_st)
	);

	// s2: speed clamp, sqrt(3)*x, spin truncation
	logic [7:0]                speed_c;
	logic signed [SPROD_W-1:0] sadj_c;
	logic                      vld_s2;
	logic signed [25:0]        sx_s2;
	logic signed [IN_W-1:0]    y_s2;
	logic [7:0]                speed_s2;
	logic [MAGQ_W-1:0]         magq_s2;
	logic signed [SPIN_W-1:0]  spin_s2;

	always_comb begin
		if (magq[15:8] < speed_min_q) begin
			speed_c = speed_min_q;
		end else if (magq[15:8] > speed_max_q) begin
			speed_c = speed_max_q;
		end else begin
			speed_c = magq[15:8];
		end
		sadj_c = sq_st.sprod + (sq_st.sprod[SPROD_W-1] ? SPROD_W'(255) : SPROD_W'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2    <= $signed({1'b0, SQRT3_Q16}) * sq_st.x;
			y_s2     <= sq_st.y;
			speed_s2 <= speed_c;
			magq_s2  <= magq;
			spin_s2  <= sadj_c[17:8];
		end
	end

	// s3: wheel direction terms
	logic signed [DOT_W-1:0]  yw_c, sxw_c;
	logic                     vld_s3;
	logic [2:0][DOT_W-1:0]    dot_s3;
	logic [24:0]              zs_s3;
	logic [7:0]               speed_s3;
	logic [MAGQ_W-1:0]        magq_s3;
	logic signed [SPIN_W-1:0] spin_s3;

	always_comb begin
		yw_c  = DOT_W'(y_s2) <<< 16;
		sxw_c = DOT_W'(sx_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3[LN_L] <= yw_c - sxw_c;
			dot_s3[LN_R] <= yw_c + sxw_c;
			dot_s3[LN_T] <= -(yw_c <<< 1);
			zs_s3        <= speed_s2 * SQRT3_Q16;
			speed_s3     <= speed_s2;
			magq_s3      <= magq_s2;
			spin_s3      <= spin_s2;
		end
	end

	// s4: speed times direction
	logic                     vld_s4;
	logic [2:0][PROD_W-1:0]   prod_s4;
	logic [24:0]              zs_s4;
	logic [MAGQ_W-1:0]        magq_s4;
	logic signed [SPIN_W-1:0] spin_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				prod_s4[l] <= $signed(dot_s3[l]) * $signed({1'b0, speed_s3});
			end
			zs_s4   <= zs_s3;
			magq_s4 <= magq_s3;
			spin_s4 <= spin_s3;
		end
	end

	// s5: magnitudes for the projection divide; zero magnitude uses angle 0
	logic [2:0][PROD_W-1:0] aprod_c;
	logic                   zero_c;
	logic                   vld_s5;
	logic [2:0][N1_W-1:0]   num_s5;
	logic [MAGQ_W-1:0]      den_s5;
	omk_mid_t               mid_s5;

	always_comb begin
		zero_c = (magq_s4 == '0);
		for (int l = 0; l < 3; l++) begin
			aprod_c[l] = prod_s4[l][PROD_W-1] ? PROD_W'(-prod_s4[l]) : prod_s4[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s5.spin <= spin_s4;
			if (zero_c) begin
				num_s5[LN_L]     <= N1_W'(zs_s4 >> 17);
				num_s5[LN_R]     <= N1_W'(zs_s4 >> 17);
				num_s5[LN_T]     <= '0;
				mid_s5.neg       <= 3'b001;
				den_s5           <= MAGQ_W'(1);
			end else begin
				for (int l = 0; l < 3; l++) begin
					num_s5[l]     <= N1_W'(aprod_c[l] >> 9);
					mid_s5.neg[l] <= prod_s4[l][PROD_W-1];
				end
				den_s5 <= magq_s4;
			end
		end
	end

	logic                 d1_vld;
	logic [2:0][Q1_W-1:0] q1;
	omk_mid_t             d1_mid;

	omk_div #(
		.LANES  (3),
		.N_W    (N1_W),
		.D_W    (MAGQ_W),
		.Q_W    (Q1_W),
		.SIDE_W ($bits(omk_mid_t))
	) u_div_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s5),
		.in_num   (num_s5),
		.in_den   (den_s5),
		.in_side  (mid_s5),
		.out_vld  (d1_vld),
		.out_quo  (q1),
		.out_rnz  (),
		.out_side (d1_mid)
	);

	// s6: signed projections, rescale factor
	logic                      vld_s6;
	logic [2:0][WHEEL_W-1:0]   p_s6;
	logic signed [SPIN_W-1:0]  spin_s6;
	logic signed [WHEEL_W-1:0] f_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				p_s6[l] <= d1_mid.neg[l] ? WHEEL_W'(-{1'b0, q1[l]}) : WHEEL_W'({1'b0, q1[l]});
			end
			spin_s6 <= d1_mid.spin;
			f_s6    <= $signed({3'b000, speed_max_q}) - WHEEL_W'(d1_mid.spin);
		end
	end

	// s7: largest wheel, limit test, rescale products
	logic signed [WHEEL_W-1:0] maxp_c;
	logic signed [WHEEL_W+1:0] mw_c;
	logic                      vld_s7;
	logic [2:0][21:0]          n_s7;
	logic [2:0][WHEEL_W-1:0]   p_s7;
	logic signed [WHEEL_W-1:0] maxp_s7;
	logic                      scl_s7;
	logic signed [SPIN_W-1:0]  spin_s7;

	always_comb begin
		maxp_c = $signed(p_s6[LN_L]);
		if ($signed(p_s6[LN_R]) > maxp_c) begin
			maxp_c = $signed(p_s6[LN_R]);
		end
		if ($signed(p_s6[LN_T]) > maxp_c) begin
			maxp_c = $signed(p_s6[LN_T]);
		end
		mw_c = (WHEEL_W+2)'(maxp_c) + (WHEEL_W+2)'(spin_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				n_s7[l] <= $signed(p_s6[l]) * f_s6;
			end
			p_s7    <= p_s6;
			maxp_s7 <= maxp_c;
			scl_s7  <= mw_c > $signed({5'b00000, speed_max_q});
			spin_s7 <= spin_s6;
		end
	end

	// s8: magnitudes and divisor for the rescale divide
	logic                 vld_s8;
	logic [2:0][N2_W-1:0] num_s8;
	logic [D2_W-1:0]      den_s8;
	omk_tail_t            tl_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				num_s8[l]    <= n_s7[l][21] ? N2_W'(-n_s7[l]) : N2_W'(n_s7[l]);
				tl_s8.neg[l] <= n_s7[l][21];
			end
			den_s8     <= (maxp_s7 > 0) ? maxp_s7[D2_W-1:0] : D2_W'(1);
			tl_s8.dz   <= !(maxp_s7 > 0);
			tl_s8.p    <= p_s7;
			tl_s8.spin <= spin_s7;
			tl_s8.scl  <= scl_s7;
		end
	end

	logic                 d2_vld;
	logic [2:0][Q2_W-1:0] q2;
	logic [2:0]           r2nz;
	omk_tail_t            d2_tl;

	omk_div #(
		.LANES  (3),
		.N_W    (N2_W),
		.D_W    (D2_W),
		.Q_W    (Q2_W),
		.SIDE_W ($bits(omk_tail_t))
	) u_div_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s8),
		.in_num   (num_s8),
		.in_den   (den_s8),
		.in_side  (tl_s8),
		.out_vld  (d2_vld),
		.out_quo  (q2),
		.out_rnz  (r2nz),
		.out_side (d2_tl)
	);

	// output: floor quotient, add spin back, saturate
	logic signed [Q2_W+1:0]  fq_c [3];
	logic signed [Q2_W+2:0]  v_c  [3];
	logic [2:0][WHEEL_W-1:0] wh_c;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (d2_tl.neg[l]) begin
				fq_c[l] = r2nz[l] ? ~{2'b00, q2[l]} : -{2'b00, q2[l]};
			end else begin
				fq_c[l] = {2'b00, q2[l]};
			end
			if (!d2_tl.scl) begin
				v_c[l] = (Q2_W+3)'($signed(d2_tl.p[l])) + (Q2_W+3)'(d2_tl.spin);
			end else if (d2_tl.dz) begin
				v_c[l] = $signed({15'd0, speed_max_q});
			end else begin
				v_c[l] = (Q2_W+3)'(fq_c[l]) + (Q2_W+3)'(d2_tl.spin);
			end
			if (v_c[l] > $signed((Q2_W+3)'(1023))) begin
				wh_c[l] = WHEEL_W'(1023);
			end else if (v_c[l] < -$signed((Q2_W+3)'(1024))) begin
				wh_c[l] = WHEEL_W'(1024);
			end else begin
				wh_c[l] = v_c[l][WHEEL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= M_TDATA_W'({d2_tl.scl, wh_c[LN_T], wh_c[LN_R], wh_c[LN_L]});
		end
	end

endmodule

@@ hw/rtl/omk_sqrt.sv @@
module omk_sqrt import omk_pkg::*; #(
	parameter int SIDE_W = 35
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [MAG2_W-1:0] in_mag2,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [MAGQ_W-1:0] out_root,
	output logic [SIDE_W-1:0] out_side
);

	// floor(sqrt(in_mag2 * 65536)), two root bits per stage
	localparam int STG   = MAGQ_W / 2;
	localparam int REM_W = MAGQ_W + 2;
	localparam int RAD_W = 2 * MAGQ_W;
	localparam int ST_W  = REM_W + MAGQ_W + RAD_W;

	function automatic logic [ST_W-1:0] sq_step(input logic [ST_W-1:0] st);
		logic [REM_W-1:0]  rem;
		logic [MAGQ_W-1:0] root;
		logic [RAD_W-1:0]  rad;
		logic [REM_W+1:0]  r2;
		logic [REM_W+1:0]  t;
		logic [ST_W-1:0]   res;
		{rem, root, rad} = st;
		r2 = {rem, rad[RAD_W-1 -: 2]};
		t  = {2'b00, root, 2'b01};
		if (r2 >= t) begin
			res = {REM_W'(r2 - t), root[MAGQ_W-2:0], 1'b1, rad[RAD_W-3:0], 2'b00};
		end else begin
			res = {REM_W'(r2), root[MAGQ_W-2:0], 1'b0, rad[RAD_W-3:0], 2'b00};
		end
		return res;
	endfunction

	logic [ST_W-1:0]   st_s   [STG];
	logic              vld_s  [STG];
	logic [SIDE_W-1:0] side_s [STG];

	for (genvar k = 0; k < STG; k++) begin : g_stg
		logic [ST_W-1:0]   st_d;
		logic              vld_d;
		logic [SIDE_W-1:0] side_d;

		if (k == 0) begin : g_first
			assign st_d   = {REM_W'(0), MAGQ_W'(0), in_mag2, {(RAD_W-MAG2_W){1'b0}}};
			assign vld_d  = in_vld;
			assign side_d = in_side;
		end else begin : g_next
			assign st_d   = st_s[k-1];
			assign vld_d  = vld_s[k-1];
			assign side_d = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_d;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k]   <= sq_step(sq_step(st_d));
				side_s[k] <= side_d;
			end
		end
	end

	assign out_vld  = vld_s[STG-1];
	assign out_root = st_s[STG-1][RAD_W +: MAGQ_W];
	assign out_side = side_s[STG-1];

endmodule

@@ hw/rtl/omk_div.sv @@
module omk_div #(
	parameter int LANES  = 3,
	parameter int N_W    = 25,
	parameter int D_W    = 16,
	parameter int Q_W    = 10,
	parameter int SIDE_W = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [LANES-1:0][N_W-1:0]   in_num,
	input  logic [D_W-1:0]              in_den,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_vld,
	output logic [LANES-1:0][Q_W-1:0]   out_quo,
	output logic [LANES-1:0]            out_rnz,
	output logic [SIDE_W-1:0]           out_side
);

	// restoring divide, common divisor, two quotient bits per stage;
	// num >> Q_W must be below the divisor
	localparam int STG  = Q_W / 2;
	localparam int RL_W = D_W + Q_W;

	function automatic logic [RL_W-1:0] div_step(input logic [RL_W-1:0] rl,
		input logic [D_W-1:0] d);
		logic [D_W:0]    t;
		logic [D_W:0]    dif;
		logic [RL_W-1:0] res;
		t   = rl[RL_W-1:Q_W-1];
		dif = t - {1'b0, d};
		if (!dif[D_W]) begin
			res = {dif[D_W-1:0], rl[Q_W-2:0], 1'b1};
		end else begin
			res = {t[D_W-1:0], rl[Q_W-2:0], 1'b0};
		end
		return res;
	endfunction

	logic [LANES-1:0][RL_W-1:0] rl_s   [STG];
	logic [D_W-1:0]             den_s  [STG];
	logic                       vld_s  [STG];
	logic [SIDE_W-1:0]          side_s [STG];

	for (genvar k = 0; k < STG; k++) begin : g_stg
		logic [LANES-1:0][RL_W-1:0] rl_d;
		logic [D_W-1:0]             den_d;
		logic                       vld_d;
		logic [SIDE_W-1:0]          side_d;

		if (k == 0) begin : g_first
			for (genvar l = 0; l < LANES; l++) begin : g_ln
				assign rl_d[l] = RL_W'(in_num[l]);
			end
			assign den_d  = in_den;
			assign vld_d  = in_vld;
			assign side_d = in_side;
		end else begin : g_next
			assign rl_d   = rl_s[k-1];
			assign den_d  = den_s[k-1];
			assign vld_d  = vld_s[k-1];
			assign side_d = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_d;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					rl_s[k][l] <= div_step(div_step(rl_d[l], den_d), den_d);
				end
				den_s[k]  <= den_d;
				side_s[k] <= side_d;
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign out_quo[l] = rl_s[STG-1][l][Q_W-1:0];
		assign out_rnz[l] = |rl_s[STG-1][l][RL_W-1:Q_W];
	end

	assign out_vld  = vld_s[STG-1];
	assign out_side = side_s[STG-1];

endmodule

@@ hw/rtl/omk_checker.sv @@
module omk_checker import omk_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	// input side opens exactly when the output register can move
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("s_axis_tready does not track output register");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled item changed");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:M_FIELD_W] == '0)
		else $error("tdata padding not zero");

	// a new item is always taken when the pipe is empty at the output
	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind three_wheel_omni_kinematics_top omk_checker u_omk_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ test/tb_top.sv @@
module tb_top;
	import omk_pkg::*;

	typedef struct {
		logic signed [WHEEL_W-1:0] left;
		logic signed [WHEEL_W-1:0] right;
		logic signed [WHEEL_W-1:0] tail;
		logic                      scaled;
	} wheels_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	three_wheel_omni_kinematics_top dut (.*);

	logic [6:0] cfg_dead;
	logic [9:0] cfg_gain;
	logic [7:0] cfg_smin;
	logic [7:0] cfg_smax;

	wheels_t wheels_q[$];
	int      n_err;
	int      cycles;
	bit      hold_rx;
	int      hold_len;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("three_wheel_omni_kinematics_top regression: fail");
			$finish;
		end
	end

	function automatic longint isqrt(longint n);
		longint r;
		r = 0;
		while ((r + 1) * (r + 1) <= n)
			r++;
		return r;
	endfunction

	function automatic longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && ((a < 0) != (b < 0)))
			q--;
		return q;
	endfunction

	function automatic longint dz(logic signed [7:0] v);
		longint a;
		a = v < 0 ? -v : v;
		return (a < cfg_dead) ? 0 : longint'(v);
	endfunction

	function automatic longint proj(longint sp, longint cx, longint cy,
			longint x, longint y, longint mq);
		if (mq == 0)
			return (sp * cx) / 131072;
		return (sp * (cx * x + cy * y)) / (mq * 512);
	endfunction

	function automatic longint sat(longint v);
		if (v < -1024)
			return -1024;
		if (v > 1023)
			return 1023;
		return v;
	endfunction

	function automatic wheels_t solve_wheels(logic signed [7:0] xi, logic signed [7:0] yi,
			logic signed [7:0] si);
		longint x, y, s, spin, m2, sp, mq, smax, m, d;
		longint w[3];
		wheels_t r;
		x = dz(xi);
		y = dz(yi);
		s = dz(si);
		spin = (longint'(cfg_gain) * s) / 256;
		m2 = x * x + y * y;
		sp = isqrt(m2);
		mq = isqrt(m2 * 65536);
		smax = cfg_smax;
		if (sp < cfg_smin)
			sp = cfg_smin;
		else if (sp > smax)
			sp = smax;
		w[0] = proj(sp, -113512, 65536, x, y, mq) + spin;
		w[1] = proj(sp, 113512, 65536, x, y, mq) + spin;
		w[2] = proj(sp, 0, -131072, x, y, mq) + spin;
		m = w[0];
		if (w[1] > m)
			m = w[1];
		if (w[2] > m)
			m = w[2];
		r.scaled = 0;
		if (m > smax) begin
			d = m - spin;
			r.scaled = 1;
			for (int i = 0; i < 3; i++)
				w[i] = (d <= 0) ? smax : fdiv((w[i] - spin) * (smax - spin), d) + spin;
		end
		r.left = sat(w[0]);
		r.right = sat(w[1]);
		r.tail = sat(w[2]);
		return r;
	endfunction

	task automatic send_stick(logic [7:0] x, logic [7:0] y, logic [7:0] s);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {s, y, x};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		wheels_q.push_back(solve_wheels(x, y, s));
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_DEAD_ZONE: cfg_dead = val[6:0];
			REG_SPIN_GAIN: cfg_gain = val[9:0];
			REG_SPEED_MIN: cfg_smin = val[7:0];
			default: cfg_smax = val[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		s_axis_tvalid <= 0;
		while (wheels_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_regs(int d, int g, int lo, int hi);
		drain();
		apb_write(REG_DEAD_ZONE, d);
		apb_write(REG_SPIN_GAIN, g);
		apb_write(REG_SPEED_MIN, lo);
		apb_write(REG_SPEED_MAX, hi);
	endtask

	task automatic send_random(int n);
		logic [7:0] x, y, s;
		for (int i = 0; i < n; i++) begin
			x = 8'($urandom);
			y = 8'($urandom);
			s = 8'($urandom);
			if ($urandom_range(0, 7) == 0)
				x = 0;
			if ($urandom_range(0, 7) == 0)
				y = 0;
			if ($urandom_range(0, 9) == 0)
				s = 8'h80;
			send_stick(x, y, s);
		end
	endtask

	task automatic test_directed;
		logic [7:0] ext[6] = '{8'h80, 8'h7f, 8'h00, 8'hff, 8'h09, 8'hf6};
		foreach (ext[i])
			send_stick(ext[i], ext[5 - i], ext[(i + 2) % 6]);
		send_stick(0, 0, 0);
		send_stick(0, 0, 8'h7f);
		send_stick(0, 0, 8'h80);
		send_stick(8'h7f, 8'h7f, 8'h7f);
		send_stick(8'h80, 8'h80, 8'h80);
		send_stick(8'h80, 0, 8'h7f);
		send_stick(0, 8'h80, 8'h80);
	endtask

	task automatic test_corner_regs;
		set_regs(0, 1023, 181, 1);
		test_directed();
		set_regs(127, 0, 0, 255);
		test_directed();
		send_random(20);
		set_regs(0, 1023, 0, 255);
		send_random(40);
		set_regs(5, 1023, 200, 50);
		send_random(40);
	endtask

	task automatic test_random_regs;
		for (int k = 0; k < 6; k++) begin
			set_regs($urandom_range(0, 30), $urandom_range(0, 1023),
				$urandom_range(0, 181), $urandom_range(1, 255));
			send_random(60);
		end
	endtask

	task automatic test_backpressure;
		hold_len = 150;
		hold_rx = 1;
		send_random(80);
		hold_rx = 0;
	endtask

	always @(posedge clk) begin
		wheels_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (wheels_q.size() == 0) begin
				$error("result with nothing expected");
				n_err++;
			end else begin
				e = wheels_q.pop_front();
				if (m_axis_tdata[10:0] !== e.left) begin
					$error("wheel_left exp %0d got %0d", e.left, $signed(m_axis_tdata[10:0]));
					n_err++;
				end
				if (m_axis_tdata[21:11] !== e.right) begin
					$error("wheel_right exp %0d got %0d", e.right,
						$signed(m_axis_tdata[21:11]));
					n_err++;
				end
				if (m_axis_tdata[32:22] !== e.tail) begin
					$error("wheel_tail exp %0d got %0d", e.tail,
						$signed(m_axis_tdata[32:22]));
					n_err++;
				end
				if (m_axis_tdata[33] !== e.scaled) begin
					$error("was_scaled exp %0d got %0d", e.scaled, m_axis_tdata[33]);
					n_err++;
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold on request
	initial begin
		int w;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_rx && hold_len > 0) begin
				m_axis_tready <= 0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
			if (w > 0) begin
				m_axis_tready <= 0;
				repeat (w) @(posedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(10, 40)) @(posedge clk);
		end
	end

	initial begin
		cycles = 0;
		n_err = 0;
		hold_rx = 0;
		hold_len = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		cfg_dead = DEAD_ZONE_RST;
		cfg_gain = SPIN_GAIN_RST;
		cfg_smin = SPEED_MIN_RST;
		cfg_smax = SPEED_MAX_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		send_random(40);
		test_corner_regs();
		test_random_regs();
		test_backpressure();
		drain();
		if (n_err == 0)
			$display("three_wheel_omni_kinematics_top regression: pass");
		else
			$display("three_wheel_omni_kinematics_top regression: fail");
		$finish;
	end
endmodule
